FILE: src/msbp_pkg.sv
// Shared constants and command codes for the MSB-first bit packer.
// No dependencies; imported by msb_first_bit_packer.
`timescale 1ns / 1ps

package msbp_pkg;

    localparam int DEFAULT_WORD_WIDTH = 32;

    localparam int VALUE_BITS  = 32;
    localparam int LENGTH_BITS = 6;
    localparam int PACKED_BITS = 32;
    localparam int COUNT_BITS  = 6;

    localparam int S_TDATA_BITS = ((VALUE_BITS + LENGTH_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((PACKED_BITS + COUNT_BITS + 7) / 8) * 8;

    typedef enum logic [0:0] {
        CMD_PUT   = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

endpackage

FILE: src/msb_first_bit_packer.sv
// Top level of the MSB-first variable-length bit packer.
// Depends on msbp_pkg for field widths, command codes and the default word width.
`timescale 1ns / 1ps

// Packs fields of 0 to WORD_WIDTH bits into WORD_WIDTH-bit words, first bit at the
// top. A put item (tuser = 0) appends field_length bits of field_value; each time
// the word fills it leaves on m_ with valid_bits = WORD_WIDTH, and spilled bits
// start the next word. A flush item (tuser = 1) sends the partial word with its
// bit count and clears it; a flush with nothing held and a zero-length put give
// no result. Lengths above WORD_WIDTH saturate. One item is taken every cycle
// while the result register is empty or m_tready is high; a result reaches m_
// through the input register, then the result register. The path between them
// is one barrel shift over a 2*WORD_WIDTH-bit window plus the fill-count add.
module msb_first_bit_packer #(
    parameter int WORD_WIDTH = msbp_pkg::DEFAULT_WORD_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] field_value, [37:32] field_length, [39:38] zero
    input  logic [msbp_pkg::S_TDATA_BITS-1:0] s_tdata,
    // [0] command
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] packed_word, [37:32] valid_bits, [39:38] zero
    output logic [msbp_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import msbp_pkg::*;

    localparam int CW  = $clog2(WORD_WIDTH + 1);
    localparam int LW  = (CW > LENGTH_BITS) ? CW : LENGTH_BITS;
    localparam int SW  = $clog2(2 * WORD_WIDTH + 1);
    localparam int VW  = (WORD_WIDTH > VALUE_BITS) ? WORD_WIDTH : VALUE_BITS;
    localparam int OW  = (CW > COUNT_BITS) ? CW : COUNT_BITS;
    localparam int DW  = 2 * WORD_WIDTH;

    // input register
    logic                   in_valid_reg;
    cmd_t                   in_cmd_reg;
    logic [VALUE_BITS-1:0]  in_value_reg;
    logic [LENGTH_BITS-1:0] in_length_reg;

    // packing state
    logic [WORD_WIDTH-1:0]  acc_reg,  acc_next;
    logic [CW-1:0]          fill_reg, fill_next;

    // result register
    logic                   out_valid_reg;
    logic [WORD_WIDTH-1:0]  out_word_reg, out_word_next;
    logic [CW-1:0]          out_count_reg, out_count_next;
    logic                   emit;

    logic                   advance;
    logic [LW-1:0]          len_ext, len_sat;
    logic [VW-1:0]          value_ext;
    logic [WORD_WIDTH-1:0]  data;
    logic [SW-1:0]          total, shift;
    logic [DW-1:0]          window;
    logic [VW-1:0]          word_ext;
    logic [OW-1:0]          count_ext;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        len_ext   = LW'(in_length_reg);
        len_sat   = (len_ext > LW'(WORD_WIDTH)) ? LW'(WORD_WIDTH) : len_ext;
        value_ext = VW'(in_value_reg);
        data      = value_ext[WORD_WIDTH-1:0] & ~({WORD_WIDTH{1'b1}} << len_sat);
        total     = SW'(fill_reg) + SW'(len_sat);
        shift     = SW'(DW) - total;
        window    = {acc_reg, {WORD_WIDTH{1'b0}}} | (DW'(data) << shift);

        acc_next       = acc_reg;
        fill_next      = fill_reg;
        out_word_next  = window[DW-1:WORD_WIDTH];
        out_count_next = CW'(WORD_WIDTH);
        emit           = 1'b0;

        case (in_cmd_reg)
            CMD_FLUSH: begin
                out_word_next  = acc_reg;
                out_count_next = fill_reg;
                emit           = (fill_reg != '0);
                acc_next       = '0;
                fill_next      = '0;
            end
            CMD_PUT: begin
                if (total >= SW'(WORD_WIDTH)) begin
                    emit      = 1'b1;
                    acc_next  = window[WORD_WIDTH-1:0];
                    fill_next = CW'(total - SW'(WORD_WIDTH));
                end else begin
                    acc_next  = window[DW-1:WORD_WIDTH];
                    fill_next = CW'(total);
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            fill_reg      <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                acc_reg       <= acc_next;
                fill_reg      <= fill_next;
                out_valid_reg <= emit;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg    <= cmd_t'(s_tuser[0]);
            in_value_reg  <= s_tdata[VALUE_BITS-1:0];
            in_length_reg <= s_tdata[VALUE_BITS +: LENGTH_BITS];
        end
        if (advance && emit) begin
            out_word_reg  <= out_word_next;
            out_count_reg <= out_count_next;
        end
    end

    always_comb begin
        word_ext  = VW'(out_word_reg);
        count_ext = OW'(out_count_reg);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'({count_ext[COUNT_BITS-1:0], word_ext[PACKED_BITS-1:0]});

    a_fill_below_word: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < CW'(WORD_WIDTH))
        else $error("fill count reached the word width");

    a_result_has_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_count_reg != '0))
        else $error("result item with zero valid bits");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == CMD_FLUSH) |=> (fill_reg == '0 && acc_reg == '0))
        else $error("flush left bits in the accumulator");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with an empty input register");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (!advance) |=> ($stable(fill_reg) && $stable(acc_reg)))
        else $error("packing state changed without an item");

endmodule

FILE: tb/tb_msb_first_bit_packer.sv
// Self-checking testbench for msb_first_bit_packer: directed and random put/flush items,
// with random idling on both sides and one long receiver hold-off.
// Depends on msbp_pkg and msb_first_bit_packer.
`timescale 1ns / 1ps

module tb_msb_first_bit_packer;
    import msbp_pkg::*;

    localparam int WORD_W      = DEFAULT_WORD_WIDTH;
    localparam int RANDOM_ITEMS = 1430;
    localparam int CALM_TAIL   = 200;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 300;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] value;
        logic [5:0]  length;
    } field_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  count;
    } packed_word_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic [0:0]              s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;

    field_item_t  pending_items[$];
    packed_word_t words_due[$];
    field_item_t  cur_item;

    logic [31:0] acc_bits = '0;
    logic [5:0]  acc_fill = '0;

    int accepted_cnt = 0;
    int total_items  = 0;
    int mismatch_cnt = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    msb_first_bit_packer #(.WORD_WIDTH(WORD_W)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic add_word(input packed_word_t w);
        words_due.insert(words_due.size(), w);
    endtask

    task automatic add_item(input field_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    // Append or flush one item, queueing the word it completes, if any.
    task automatic pack_into_word(input field_item_t it);
        logic [6:0]   len;
        logic [6:0]   room;
        logic [6:0]   spill;
        logic [63:0]  data;
        packed_word_t w;
        if (it.cmd == CMD_FLUSH) begin
            if (acc_fill != 0) begin
                w.word  = acc_bits;
                w.count = acc_fill;
                add_word(w);
            end
            acc_bits = '0;
            acc_fill = '0;
        end else begin
            len = (it.length > WORD_W) ? 7'(WORD_W) : 7'(it.length);
            if (len != 0) begin
                data = 64'(it.value) & ((64'd1 << len) - 64'd1);
                room = 7'(WORD_W) - 7'(acc_fill);
                if (len < room) begin
                    acc_bits = acc_bits | 32'(data << (room - len));
                    acc_fill = acc_fill + 6'(len);
                end else begin
                    spill   = len - room;
                    w.word  = acc_bits | 32'(data >> spill);
                    w.count = 6'(WORD_W);
                    add_word(w);
                    acc_bits = (spill == 0) ? 32'd0 : 32'(data << (7'(WORD_W) - spill));
                    acc_fill = 6'(spill);
                end
            end
        end
    endtask

    function automatic field_item_t make_item(cmd_t cmd, logic [31:0] value,
                                              logic [5:0] length);
        field_item_t it;
        it.cmd    = cmd;
        it.value  = value;
        it.length = length;
        return it;
    endfunction

    function automatic field_item_t random_item();
        field_item_t it;
        int pick;
        it.cmd = ($urandom_range(0, 99) < 9) ? CMD_FLUSH : CMD_PUT;
        pick = $urandom_range(0, 9);
        case (pick)
            0: it.length = 6'd0;
            1: it.length = 6'd32;
            2: it.length = 6'($urandom_range(33, 63));
            3: it.length = 6'd1;
            default: it.length = 6'($urandom_range(1, 31));
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0: it.value = 32'h0;
            1: it.value = 32'hFFFF_FFFF;
            default: it.value = $urandom();
        endcase
        return it;
    endfunction

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pack_into_word(cur_item);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, cur_item.length, cur_item.value};
                    s_tuser  <= cur_item.cmd;
                    if (accepted_cnt + CALM_TAIL < total_items && hold_left == 0 &&
                        $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(1, 17);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Monitor
    always @(posedge aclk) begin
        packed_word_t exp_w;
        logic         ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (words_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h count %0d",
                                              m_tdata[31:0], m_tdata[37:32]));
                end else begin
                    exp_w = words_due.pop_front();
                    if (m_tdata[31:0] !== exp_w.word) begin
                        report_mismatch($sformatf("packed_word %h, expected %h",
                                                  m_tdata[31:0], exp_w.word));
                    end
                    if (m_tdata[37:32] !== exp_w.count) begin
                        report_mismatch($sformatf("valid_bits %0d, expected %0d",
                                                  m_tdata[37:32], exp_w.count));
                    end
                end
            end
            if (hold_left > 0) begin
                ready_next = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                ready_next = 1'b0;
            end else if (accepted_cnt + CALM_TAIL < total_items &&
                         $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 16);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    // Stimulus and end of run
    initial begin
        add_item(make_item(CMD_PUT,   32'hFFFF_FFFF, 6'd0));
        add_item(make_item(CMD_FLUSH, 32'hFFFF_FFFF, 6'd63));
        add_item(make_item(CMD_PUT,   32'hFFFF_FFFF, 6'd32));
        add_item(make_item(CMD_PUT,   32'hA5A5_A5A5, 6'd63));
        add_item(make_item(CMD_PUT,   32'h1234_5678, 6'd33));
        add_item(make_item(CMD_PUT,   32'h0000_0001, 6'd1));
        add_item(make_item(CMD_PUT,   32'hFFFF_FFF5, 6'd3));
        add_item(make_item(CMD_PUT,   32'h7FFF_FFFF, 6'd31));
        add_item(make_item(CMD_FLUSH, 32'h0,         6'd0));
        add_item(make_item(CMD_FLUSH, 32'h0,         6'd0));
        add_item(make_item(CMD_PUT,   32'h0,         6'd31));
        add_item(make_item(CMD_PUT,   32'hFFFF_FFFF, 6'd1));
        add_item(make_item(CMD_PUT,   32'h000A_BCDE, 6'd20));
        add_item(make_item(CMD_PUT,   32'h0001_2345, 6'd20));
        add_item(make_item(CMD_PUT,   32'hDEAD_BEEF, 6'd32));
        add_item(make_item(CMD_PUT,   32'hFFFF_FFFF, 6'd0));
        add_item(make_item(CMD_FLUSH, 32'h0,         6'd0));
        add_item(make_item(CMD_PUT,   32'hFFFF_FFFE, 6'd1));
        add_item(make_item(CMD_FLUSH, 32'h0,         6'd0));
        add_item(make_item(CMD_PUT,   32'h7FFF_FFFF, 6'd31));
        add_item(make_item(CMD_FLUSH, 32'hFFFF_FFFF, 6'd63));
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            add_item(random_item());
        end
        add_item(make_item(CMD_FLUSH, 32'h0, 6'd0));
        total_items = pending_items.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt < total_items) @(posedge aclk);
        while (words_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
